/* hdl/framed_message_ring_buffer_defines.svh */
// assertion macros for the framed message ring buffer
`ifndef FRAMED_MESSAGE_RING_BUFFER_DEFINES_SVH
`define FRAMED_MESSAGE_RING_BUFFER_DEFINES_SVH
`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define FMRB_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("fmrb assertion failed");
// antecedent implies consequent in the same cycle
`define FMRB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fmrb implication failed");
`else
`define FMRB_ASSERT(lbl, clk, rst_n, cond)
`define FMRB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/fmrb_pkg.sv */
// shared types, constants and helpers of the framed message ring buffer
`default_nettype none
package fmrb_pkg;

	localparam int RING_BYTES   = 4096;
	localparam int HEADER_BYTES = 8;
	localparam int PTR_W        = $clog2(RING_BYTES);
	localparam int CNT_W        = $clog2(RING_BYTES + 1);

	// operation codes
	localparam logic [2:0] OP_PUSH_HDR  = 3'd0;
	localparam logic [2:0] OP_PUSH_DATA = 3'd1;
	localparam logic [2:0] OP_OPEN      = 3'd2;
	localparam logic [2:0] OP_READ      = 3'd3;
	localparam logic [2:0] OP_DISCARD   = 3'd4;
	localparam logic [2:0] OP_BAD       = 3'd7;

	// status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NOT_ENOUGH = 3'd1;
	localparam logic [2:0] ST_NO_HEADER  = 3'd2;
	localparam logic [2:0] ST_PARTIAL    = 3'd3;
	localparam logic [2:0] ST_BAD_PARAM  = 3'd4;
	localparam logic [2:0] ST_BAD_SEQ    = 3'd5;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] msg_index;
		logic [15:0] msg_type;
		logic [15:0] msg_length;
		logic [7:0]  data_byte;
		logic [15:0] capacity;
		logic        consume;
		logic [16:0] total_length_in;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] out_index;
		logic [15:0] out_type;
		logic [15:0] out_length;
		logic [16:0] total_length;
		logic [7:0]  out_byte;
		logic        last;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [2:0] op;
		in_item_t   item;
	} cmd_t;

	// state seen by the checks at the top level
	typedef struct packed {
		logic [CNT_W-1:0] used;
		logic             push_active;
		logic             read_active;
	} back_status_t;

	// ring position plus an offset no larger than the ring
	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] pos,
			input logic [16:0] amt);
		logic [17:0] s;
		s = 18'(pos) + 18'(amt);
		if (s >= 18'(RING_BYTES)) begin
			s = s - 18'(RING_BYTES);
		end
		return PTR_W'(s);
	endfunction

endpackage
`default_nettype wire

/* hdl/fmrb_if.sv */
// valid/ready channel interfaces for request and result beats
`default_nettype none
interface fmrb_in_if import fmrb_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface fmrb_out_if import fmrb_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/framed_message_ring_buffer.sv */
// top level of the framed message ring buffer
// Usage: request beats on req carry one operation each (push header, push
// data byte, open, read data byte, discard); every request gives exactly one
// result beat on rsp, in order. Both channels are valid/ready.
// The front queues up to two requests, so req stays ready while the back
// works or while a result waits on a stalled rsp, until both slots are full.
// Steps of each request in the back, after it leaves the queue:
//   push data byte, and a request refused before any memory access: dequeue
//   read data byte: dequeue, then result from the registered memory read
//   push header: dequeue, then one header byte written per cycle
//   open and discard once a header is present, refused or not: dequeue,
//     header read of eight bytes through the registered read, one check
// A new request starts in the back only when the result register is free or
// being taken, so a stalled rsp holds the back and then fills the queue.
// Reset clears positions, counts and flags; ring contents are not cleared,
// and are never read before they are written.
`default_nettype none
`include "framed_message_ring_buffer_defines.svh"
module framed_message_ring_buffer import fmrb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	fmrb_in_if.sink   req,
	fmrb_out_if.source rsp
);

	logic         cmd_valid;
	cmd_t         cmd;
	logic         cmd_pop;
	back_status_t stat;

	fmrb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	fmrb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp),
		.stat      (stat)
	);

	// committed bytes never exceed the ring
	`FMRB_ASSERT(a_used_bound, clk, arst_n, stat.used <= CNT_W'(RING_BYTES))
	// an open read always sits on a committed header
	`FMRB_ASSERT_IMPL(a_read_has_msg, clk, arst_n, stat.read_active,
		stat.used >= CNT_W'(HEADER_BYTES))
	// a last-byte beat is always a good read
	`FMRB_ASSERT_IMPL(a_last_ok, clk, arst_n, rsp.valid && rsp.data.last,
		rsp.data.status == ST_OK)

endmodule
`default_nettype wire

/* hdl/fmrb_front.sv */
// front end: accepts request beats, classifies them and queues two deep
`default_nettype none
module fmrb_front import fmrb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	fmrb_in_if.sink   req,
	output logic      cmd_valid,
	output cmd_t      cmd,
	input  wire logic cmd_pop
);

	cmd_t       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       cls;

	// classify the mode
	always_comb begin
		cls.item = req.data;
		unique case (req.data.mode) inside
			OP_PUSH_HDR, OP_PUSH_DATA, OP_OPEN, OP_READ, OP_DISCARD: cls.op = req.data.mode;
			default: cls.op = OP_BAD;
		endcase
	end

	assign req.ready = (count_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = q_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule
`default_nettype wire

/* hdl/fmrb_back.sv */
// back end: ring memory, write and read sequencer, result register
`default_nettype none
module fmrb_back import fmrb_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cmd_valid,
	input  wire cmd_t    cmd,
	output logic         cmd_pop,
	fmrb_out_if.source   rsp,
	output back_status_t stat
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WHDR  = 3'd1;
	localparam logic [2:0] S_RHDR  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_RBYTE = 3'd4;

	logic [7:0]       mem_q [RING_BYTES];
	logic [7:0]       rd_data_q;
	logic [7:0]       hdr_q [HEADER_BYTES];
	cmd_t             cmd_q;
	out_item_t        res_q;
	logic             res_valid_q;

	logic [2:0]       state_q, state_d;
	logic [3:0]       cnt_q, cnt_d;
	logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d, cur_q, cur_d;
	logic [CNT_W-1:0] used_q, used_d;
	logic [15:0]      prem_q, prem_d, rrem_q, rrem_d;
	logic [16:0]      ptot_q, ptot_d, otot_q, otot_d;
	logic             pact_q, pact_d, ract_q, ract_d, rcons_q, rcons_d;

	logic             slot_free;
	logic             res_set;
	out_item_t        res_n;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr, rd_addr;
	logic [7:0]       wr_data;
	logic [15:0]      h_len;
	logic [16:0]      h_tot;

	assign slot_free = !res_valid_q || rsp.ready;
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid && slot_free;
	assign h_len     = {hdr_q[7], hdr_q[6]};
	assign h_tot     = 17'(h_len) + 17'(HEADER_BYTES);

	// sequencer next state
	always_comb begin
		state_d = state_q; cnt_d = cnt_q;
		head_d = head_q; tail_d = tail_q; cur_d = cur_q; used_d = used_q;
		prem_d = prem_q; rrem_d = rrem_q; ptot_d = ptot_q; otot_d = otot_q;
		pact_d = pact_q; ract_d = ract_q; rcons_d = rcons_q;
		res_set = 1'b0; res_n = '0;
		wr_en = 1'b0; wr_addr = tail_q; wr_data = cmd.item.data_byte;
		rd_addr = cur_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_pop) begin
					case (cmd.op)
						OP_PUSH_HDR: begin
							if (pact_q) begin
								res_set = 1'b1; res_n.status = ST_BAD_SEQ;
							end else if (18'(used_q) + 18'(HEADER_BYTES)
									+ 18'(cmd.item.msg_length) > 18'(RING_BYTES)) begin
								res_set = 1'b1; res_n.status = ST_NOT_ENOUGH;
							end else begin
								state_d = S_WHDR; cnt_d = '0;
							end
						end
						OP_PUSH_DATA: begin
							res_set = 1'b1;
							if (!pact_q) begin
								res_n.status = ST_BAD_SEQ;
							end else begin
								wr_en = 1'b1;
								tail_d = wrap_add(tail_q, 17'd1);
								prem_d = prem_q - 16'd1;
								if (prem_q == 16'd1) begin
									used_d = CNT_W'(17'(used_q) + ptot_q);
									pact_d = 1'b0;
								end
							end
						end
						OP_OPEN: begin
							if (ract_q) begin
								res_set = 1'b1; res_n.status = ST_BAD_SEQ;
							end else if (used_q < CNT_W'(HEADER_BYTES)) begin
								res_set = 1'b1; res_n.status = ST_NO_HEADER;
							end else begin
								state_d = S_RHDR; cnt_d = '0;
							end
						end
						OP_READ: begin
							if (!ract_q) begin
								res_set = 1'b1; res_n.status = ST_BAD_SEQ;
							end else begin
								state_d = S_RBYTE;
							end
						end
						OP_DISCARD: begin
							if (used_q < CNT_W'(HEADER_BYTES)) begin
								res_set = 1'b1; res_n.status = ST_BAD_PARAM;
							end else begin
								state_d = S_RHDR; cnt_d = '0;
							end
						end
						default: begin
							res_set = 1'b1; res_n.status = ST_BAD_PARAM;
						end
					endcase
				end
			end
			S_WHDR: begin
				wr_en   = 1'b1;
				wr_data = hdr_q[cnt_q[2:0]];
				tail_d  = wrap_add(tail_q, 17'd1);
				cnt_d   = cnt_q + 4'd1;
				if (cnt_q == 4'(HEADER_BYTES - 1)) begin
					state_d = S_IDLE;
					res_set = 1'b1;
					ptot_d  = 17'(cmd_q.item.msg_length) + 17'(HEADER_BYTES);
					prem_d  = cmd_q.item.msg_length;
					if (cmd_q.item.msg_length == 16'd0) begin
						used_d = CNT_W'(17'(used_q) + 17'(HEADER_BYTES));
						pact_d = 1'b0;
					end else begin
						pact_d = 1'b1;
					end
				end
			end
			S_RHDR: begin
				rd_addr = wrap_add(head_q, 17'(cnt_q));
				cnt_d   = cnt_q + 4'd1;
				if (cnt_q == 4'(HEADER_BYTES)) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = S_IDLE;
				res_set = 1'b1;
				if (cmd_q.op == OP_OPEN) begin
					if (h_len > cmd_q.item.capacity) begin
						res_n.status = ST_NOT_ENOUGH;
					end else if (h_tot > 17'(used_q)) begin
						res_n.status = ST_PARTIAL;
					end else begin
						res_n.out_index  = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
						res_n.out_type   = {hdr_q[5], hdr_q[4]};
						res_n.out_length = h_len;
						otot_d = h_tot;
						if (!cmd_q.item.consume) begin
							res_n.total_length = h_tot;
						end
						if (h_len == 16'd0) begin
							if (cmd_q.item.consume) begin
								head_d = wrap_add(head_q, h_tot);
								used_d = CNT_W'(17'(used_q) - h_tot);
								otot_d = '0;
							end
						end else begin
							ract_d  = 1'b1;
							rcons_d = cmd_q.item.consume;
							cur_d   = wrap_add(head_q, 17'(HEADER_BYTES));
							rrem_d  = h_len;
						end
					end
				end else begin
					if (h_tot > 17'(used_q) || h_tot != cmd_q.item.total_length_in) begin
						res_n.status = ST_BAD_PARAM;
					end else begin
						head_d = wrap_add(head_q, h_tot);
						used_d = CNT_W'(17'(used_q) - h_tot);
						ract_d = 1'b0;
						rrem_d = '0;
						otot_d = '0;
					end
				end
			end
			S_RBYTE: begin
				state_d        = S_IDLE;
				res_set        = 1'b1;
				res_n.out_byte = rd_data_q;
				cur_d          = wrap_add(cur_q, 17'd1);
				rrem_d         = rrem_q - 16'd1;
				if (rrem_q == 16'd1) begin
					res_n.last = 1'b1;
					ract_d     = 1'b0;
					if (rcons_q) begin
						head_d = wrap_add(head_q, otot_q);
						used_d = CNT_W'(17'(used_q) - otot_q);
						otot_d = '0;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ring memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// command latch, header bytes and result payload
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (cmd_pop && cmd.op == OP_PUSH_HDR) begin
			{hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4], hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]}
				<= {cmd.item.msg_length, cmd.item.msg_type, cmd.item.msg_index};
		end else if (state_q == S_RHDR && cnt_q != 4'd0) begin
			hdr_q[3'(cnt_q - 4'd1)] <= rd_data_q;
		end
		if (res_set) begin
			res_q <= res_n;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; cnt_q <= '0;
			head_q <= '0; tail_q <= '0; cur_q <= '0; used_q <= '0;
			prem_q <= '0; rrem_q <= '0; ptot_q <= '0; otot_q <= '0;
			pact_q <= 1'b0; ract_q <= 1'b0; rcons_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d; cnt_q <= cnt_d;
			head_q <= head_d; tail_q <= tail_d; cur_q <= cur_d; used_q <= used_d;
			prem_q <= prem_d; rrem_q <= rrem_d; ptot_q <= ptot_d; otot_q <= otot_d;
			pact_q <= pact_d; ract_q <= ract_d; rcons_q <= rcons_d;
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = res_valid_q;
	assign rsp.data         = res_q;
	assign stat.used        = used_q;
	assign stat.push_active = pact_q;
	assign stat.read_active = ract_q;

endmodule
`default_nettype wire

/* sim/fmrb_tb_if.sv */
// testbench package: run limits of the framed message ring buffer bench
package fmrb_tb_pkg;
	import fmrb_pkg::*;
	// bound on a single run, in clock cycles
	localparam int CYCLE_LIMIT = 2000000;
endpackage

/* sim/framed_message_ring_buffer_tb.sv */
// testbench of the framed message ring buffer: directed and random message traffic
`default_nettype none
module framed_message_ring_buffer_tb;
	import fmrb_pkg::*;
	import fmrb_tb_pkg::*;

	logic clk;
	logic arst_n;
	fmrb_in_if  req();
	fmrb_out_if rsp();

	framed_message_ring_buffer u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	// clock
	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// ring mirror
	logic [7:0]  ring_mem [RING_BYTES];
	logic [11:0] head_q, tail_q, cur_q;
	int          used_q, push_left, push_tot, rd_left, open_tot;
	bit          push_on, rd_on, rd_pop;

	in_item_t  pend_q [$];
	out_item_t exp_q [$];
	int  errors, mism, cycles;
	bit  stim_done, hold_rx;

	function automatic logic [11:0] wadd(logic [11:0] p, int n);
		return 12'((int'(p) + n) % RING_BYTES);
	endfunction

	function automatic void ring_put(logic [7:0] b);
		ring_mem[tail_q] = b;
		tail_q = wadd(tail_q, 1);
	endfunction

	// header at the head: 0 ok, no header, partial
	function automatic logic [2:0] head_hdr(output logic [31:0] ix, output logic [15:0] ty,
			output logic [15:0] ln);
		logic [7:0] b [8];
		ix = '0; ty = '0; ln = '0;
		if (used_q < HEADER_BYTES) return ST_NO_HEADER;
		for (int i = 0; i < 8; i++) b[i] = ring_mem[wadd(head_q, i)];
		ix = {b[3], b[2], b[1], b[0]};
		ty = {b[5], b[4]};
		ln = {b[7], b[6]};
		if (HEADER_BYTES + int'(ln) > used_q) return ST_PARTIAL;
		return ST_OK;
	endfunction

	// expected result of one beat, updating the mirror
	function automatic out_item_t ring_predict(in_item_t it);
		out_item_t o;
		logic [31:0] ix;
		logic [15:0] ty, ln;
		logic [2:0] r;
		o = '0;
		case (it.mode)
			OP_PUSH_HDR: begin
				if (push_on) o.status = ST_BAD_SEQ;
				else if (used_q + 8 + int'(it.msg_length) > RING_BYTES)
					o.status = ST_NOT_ENOUGH;
				else begin
					for (int i = 0; i < 4; i++) ring_put(it.msg_index[8*i +: 8]);
					ring_put(it.msg_type[7:0]); ring_put(it.msg_type[15:8]);
					ring_put(it.msg_length[7:0]); ring_put(it.msg_length[15:8]);
					push_tot = 8 + int'(it.msg_length);
					push_left = it.msg_length;
					if (it.msg_length == 0) begin
						used_q += push_tot; push_on = 0;
					end else push_on = 1;
				end
			end
			OP_PUSH_DATA: begin
				if (!push_on) o.status = ST_BAD_SEQ;
				else begin
					ring_put(it.data_byte);
					push_left--;
					if (push_left == 0) begin
						used_q += push_tot; push_on = 0;
					end
				end
			end
			OP_OPEN: begin
				if (rd_on) o.status = ST_BAD_SEQ;
				else begin
					r = head_hdr(ix, ty, ln);
					if (r == ST_NO_HEADER) o.status = ST_NO_HEADER;
					else if (ln > it.capacity) o.status = ST_NOT_ENOUGH;
					else if (r == ST_PARTIAL) o.status = ST_PARTIAL;
					else begin
						o.out_index = ix; o.out_type = ty; o.out_length = ln;
						open_tot = 8 + int'(ln);
						if (!it.consume) o.total_length = 17'(open_tot);
						if (ln == 0) begin
							if (it.consume) begin
								head_q = wadd(head_q, open_tot);
								used_q -= open_tot; open_tot = 0;
							end
						end else begin
							rd_on = 1; rd_pop = it.consume;
							cur_q = wadd(head_q, 8); rd_left = ln;
						end
					end
				end
			end
			OP_READ: begin
				if (!rd_on) o.status = ST_BAD_SEQ;
				else begin
					o.out_byte = ring_mem[cur_q];
					cur_q = wadd(cur_q, 1);
					rd_left--;
					if (rd_left == 0) begin
						o.last = 1; rd_on = 0;
						if (rd_pop) begin
							head_q = wadd(head_q, open_tot);
							used_q -= open_tot; open_tot = 0;
						end
					end
				end
			end
			OP_DISCARD: begin
				r = head_hdr(ix, ty, ln);
				if (r != ST_OK || 8 + int'(ln) != int'(it.total_length_in))
					o.status = ST_BAD_PARAM;
				else begin
					head_q = wadd(head_q, it.total_length_in);
					used_q -= it.total_length_in;
					rd_on = 0; rd_left = 0; open_tot = 0;
				end
			end
			default: o.status = ST_BAD_PARAM;
		endcase
		return o;
	endfunction

	function automatic in_item_t rand_beat(logic [2:0] m);
		in_item_t it;
		it.mode = m;
		it.msg_index = $urandom;
		it.msg_type = 16'($urandom);
		it.msg_length = 16'($urandom_range(0, 12));
		it.data_byte = 8'($urandom);
		it.capacity = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 6)) : 16'hffff;
		it.consume = 1'($urandom);
		it.total_length_in = 17'($urandom);
		return it;
	endfunction

	task automatic add_beat(in_item_t it);
		pend_q.push_back(it);
	endtask

	// one message: header then its data bytes
	task automatic add_msg(int len, bit bigbyte);
		in_item_t it;
		it = rand_beat(OP_PUSH_HDR);
		it.msg_length = 16'(len);
		add_beat(it);
		for (int i = 0; i < len; i++) begin
			it = rand_beat(OP_PUSH_DATA);
			if (bigbyte) it.data_byte = (i % 2) ? 8'hff : 8'h00;
			add_beat(it);
		end
	endtask

	task automatic add_read(bit cons, int cap, int rd);
		in_item_t it;
		it = rand_beat(OP_OPEN);
		it.consume = cons;
		it.capacity = 16'(cap);
		add_beat(it);
		for (int i = 0; i < rd; i++) add_beat(rand_beat(OP_READ));
	endtask

	// stimulus
	initial begin
		in_item_t it;
		int len;
		stim_done = 0;
		// directed: sequence errors, bad modes and empty ring
		add_beat(rand_beat(OP_PUSH_DATA));
		add_beat(rand_beat(OP_READ));
		add_read(1, 16'hffff, 0);
		it = rand_beat(OP_DISCARD); add_beat(it);
		it = rand_beat(3'd5); add_beat(it);
		it = rand_beat(3'd6); add_beat(it);
		it = rand_beat(OP_BAD); add_beat(it);
		// extreme header fields, empty message, then opens, reads and discards
		it = rand_beat(OP_PUSH_HDR);
		it.msg_index = '1; it.msg_type = '1; it.msg_length = 0;
		add_beat(it);
		it = rand_beat(OP_PUSH_HDR); it.msg_length = 16'hffff; add_beat(it);
		add_msg(3, 1);
		add_read(0, 0, 0);
		it = rand_beat(OP_DISCARD); it.total_length_in = 17'd9; add_beat(it);
		it = rand_beat(OP_DISCARD); it.total_length_in = 17'd8; add_beat(it);
		add_read(1, 2, 0);
		add_read(0, 3, 2);
		add_beat(rand_beat(OP_OPEN));
		add_beat(rand_beat(OP_READ));
		it = rand_beat(OP_DISCARD); it.total_length_in = 17'd11; add_beat(it);
		// random traffic, mostly well formed
		while (pend_q.size() < 1950) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					len = $urandom_range(0, 14);
					add_msg(len, 0);
					if ($urandom_range(0, 9) == 0) add_beat(rand_beat(OP_PUSH_HDR));
				end
				4, 5, 6: begin
					it = rand_beat(OP_OPEN);
					add_beat(it);
					for (int i = 0; i < $urandom_range(0, 16); i++)
						add_beat(rand_beat(OP_READ));
				end
				7: begin
					it = rand_beat(OP_DISCARD);
					it.total_length_in = ($urandom_range(0, 3) == 0) ? 17'($urandom)
						: 17'($urandom_range(8, 22));
					add_beat(it);
				end
				8: add_beat(rand_beat(3'($urandom_range(0, 7))));
				default: begin
					// large message toward the full ring
					it = rand_beat(OP_PUSH_HDR);
					it.msg_length = 16'($urandom_range(1000, 4200));
					add_beat(it);
					if (it.msg_length <= 4088)
						for (int i = 0; i < 40; i++) add_beat(rand_beat(OP_PUSH_DATA));
				end
			endcase
		end
		stim_done = 1;
	end

	// driver
	int  gap, sent;
	bit  pause_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data  <= '0;
			gap = 0; sent = 0; pause_done = 0;
		end else begin
			if (req.valid && req.ready) begin
				exp_q.push_back(ring_predict(req.data));
				sent++;
			end
			if (!req.valid || req.ready) begin
				if (sent == 1000 && !pause_done && exp_q.size() != 0) begin
					req.valid <= 1'b0;
				end else if (gap > 0) begin
					gap--;
					req.valid <= 1'b0;
				end else if (pend_q.size() != 0) begin
					if (sent == 1000) pause_done = 1;
					req.valid <= 1'b1;
					req.data  <= pend_q.pop_front();
					if ((sent / 300) % 2 == 1) gap = 0;
					else if ($urandom_range(0, 19) == 0) gap = $urandom_range(5, 30);
					else gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with one long hold-off
	int stall, rx_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall = 0; hold_rx = 0;
		end else begin
			if (rx_cnt == 200 && !hold_rx) begin
				hold_rx = 1; stall = 400;
			end
			if (stall > 0) begin
				stall--;
				rsp.ready <= 1'b0;
			end else if ((rx_cnt / 250) % 2 == 1) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 49) == 0) stall = $urandom_range(5, 40);
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			rx_cnt = 0;
		end else if (rsp.valid && rsp.ready) begin
			rx_cnt++;
			if (exp_q.size() == 0) begin
				errors++;
				if (mism < 10) $display("unexpected result beat %p", rsp.data);
				mism++;
			end else begin
				want = exp_q.pop_front();
				if (rsp.data !== want) begin
					errors++;
					if (mism < 10)
						$display("mismatch beat %0d: exp %p got %p", rx_cnt, want, rsp.data);
					mism++;
				end
			end
		end
	end

	// reset, end of run and timeout
	initial begin
		errors = 0; mism = 0; cycles = 0;
		head_q = '0; tail_q = '0; cur_q = '0; used_q = 0;
		push_left = 0; push_tot = 0; rd_left = 0; open_tot = 0;
		push_on = 0; rd_on = 0; rd_pop = 0;
		req.valid = 1'b0; req.data = '0; rsp.ready = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// sample away from the active edge so driver updates have settled
		while (!(stim_done && pend_q.size() == 0 && !req.valid && exp_q.size() == 0)
				&& cycles < CYCLE_LIMIT) begin
			@(negedge clk);
			cycles++;
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
		end else begin
			repeat (20) @(posedge clk);
			if (errors == 0 && exp_q.size() == 0 && pend_q.size() == 0)
				$display("*** PASSED ***");
			else $display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
